[hdl/fiat_pkg.sv]
// Shared codes and the query token that travels down the cell chain.
package fiat_pkg;

  localparam int KeyWidth = 32;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_GEN    = 2'd2;

  // Status codes carried on the output tuser
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // One query moving from cell to cell
  typedef struct packed {
    logic                 active;
    logic [1:0]           op;
    logic [KeyWidth-1:0]  key;
    logic                 attr;      // attribute to store (add or generated)
    logic                 hit;       // key matched in an earlier cell
    logic                 hit_attr;  // stored attribute of the matching entry
    logic                 ins;       // key was appended by an earlier cell
  } token_t;

endpackage

[hdl/file_id_attribute_table.sv]
// Top level: file identifier attribute table built as a chain of entry cells.
// Each beat carries one operation (add, lookup, generate) that is injected into a
// row of TABLE_DEPTH cells and moves one cell per clock; every cell compares its
// stored identifier and the first free cell takes an insert. The result leaves the
// last cell and is registered on the output, or in a pending slot while the output
// beat still waits. The next input beat is accepted only once the token has left
// the chain and no result is pending, so operations never overlap in the chain.
// A finished result may wait on the output while the next operation runs. Inserts
// into a full table are dropped and report table full.
module file_id_attribute_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] file_id, [32] attr_in, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] attr_out, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  typedef enum logic {ST_IDLE, ST_BUSY} state_t;

  state_t                 state;
  fiat_pkg::token_t       inj;
  fiat_pkg::token_t       tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0]   tok_act;
  logic [TABLE_DEPTH-1:0] used;
  logic                   toggle;
  logic                   s_accept;
  logic                   gen_attr;
  logic [1:0]             res_status;
  logic                   res_attr;
  logic [1:0]             out_status;
  logic                   out_attr;
  logic                   pend_valid;
  logic [1:0]             pend_status;
  logic                   pend_attr;

  assign tok[0]   = inj;
  assign s_tready = (state == ST_IDLE) && !pend_valid;
  assign s_accept = s_tvalid && s_tready;
  assign gen_attr = (s_tuser == fiat_pkg::OP_GEN) ? toggle : s_tdata[32];
  assign m_tdata  = {7'd0, out_attr};
  assign m_tuser  = out_status;

  // Build the cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    fiat_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .used    (used[i])
    );
  end

  for (genvar i = 0; i <= TABLE_DEPTH; i++) begin : g_act
    assign tok_act[i] = tok[i].active;
  end

  // Resolve the token leaving the last cell
  always_comb begin
    res_status = fiat_pkg::ST_NOT_FOUND;
    res_attr   = 1'b0;
    case (tok[TABLE_DEPTH].op)
      fiat_pkg::OP_ADD, fiat_pkg::OP_GEN: begin
        if (tok[TABLE_DEPTH].hit) begin
          res_status = fiat_pkg::ST_PRESENT;
        end else if (tok[TABLE_DEPTH].ins) begin
          res_status = fiat_pkg::ST_OK;
        end else begin
          res_status = fiat_pkg::ST_FULL;
        end
        if (tok[TABLE_DEPTH].op == fiat_pkg::OP_GEN) begin
          res_attr = tok[TABLE_DEPTH].attr;
        end
      end
      fiat_pkg::OP_LOOKUP: begin
        if (tok[TABLE_DEPTH].hit) begin
          res_status = fiat_pkg::ST_OK;
          res_attr   = tok[TABLE_DEPTH].hit_attr;
        end
      end
      default: begin
        res_status = fiat_pkg::ST_NOT_FOUND;
        res_attr   = 1'b0;
      end
    endcase
  end

  // Sequence operations, inject tokens and hold results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      inj.active <= 1'b0;
      toggle     <= 1'b0;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      inj.active <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            inj.active   <= 1'b1;
            inj.op       <= s_tuser;
            inj.key      <= s_tdata[31:0];
            inj.attr     <= gen_attr;
            inj.hit      <= 1'b0;
            inj.hit_attr <= 1'b0;
            inj.ins      <= 1'b0;
            if (s_tuser == fiat_pkg::OP_GEN) begin
              toggle <= ~toggle;
            end
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (tok[TABLE_DEPTH].active) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Capture a finished result, else drain the output beat and refill from the pending slot
      if (tok[TABLE_DEPTH].active) begin
        if (!m_tvalid || m_tready) begin
          out_status <= res_status;
          out_attr   <= res_attr;
          m_tvalid   <= 1'b1;
        end else begin
          pend_status <= res_status;
          pend_attr   <= res_attr;
          pend_valid  <= 1'b1;
        end
      end else if (m_tvalid && m_tready) begin
        if (pend_valid) begin
          out_status <= pend_status;
          out_attr   <= pend_attr;
          pend_valid <= 1'b0;
        end else begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  // At most one query in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_act) <= 1)
    else $error("more than one token in the cell chain");

  // Input is taken only with an empty chain
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (tok_act == '0))
    else $error("input ready while a token is in flight");

  // Occupied entries form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((used >> 1) & ~used) == '0)
    else $error("occupied entries are not contiguous");

  // A pending result implies a waiting output beat
  a_pend: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> m_tvalid)
    else $error("pending result without an output beat");

endmodule

[hdl/fiat_cell.sv]
// One table entry: holds a key and attribute, checks and forwards the query token.
module fiat_cell (
  input  logic              clk,
  input  logic              rst,
  input  fiat_pkg::token_t  tok_in,
  output fiat_pkg::token_t  tok_out,
  output logic              used
);

  logic [fiat_pkg::KeyWidth-1:0] key_q;
  logic                          attr_q;
  logic                          wr;
  logic                          is_insert;
  fiat_pkg::token_t              tok_next;

  assign is_insert = (tok_in.op == fiat_pkg::OP_ADD) || (tok_in.op == fiat_pkg::OP_GEN);

  // Match an occupied entry, or claim the first free one for an insert
  always_comb begin
    tok_next = tok_in;
    wr       = 1'b0;
    if (tok_in.active) begin
      if (used && !tok_in.hit && (key_q == tok_in.key)) begin
        tok_next.hit      = 1'b1;
        tok_next.hit_attr = attr_q;
      end else if (!used && !tok_in.hit && !tok_in.ins && is_insert) begin
        tok_next.ins = 1'b1;
        wr           = 1'b1;
      end
    end
  end

  // Store the entry payload
  always_ff @(posedge clk) begin
    if (wr) begin
      key_q  <= tok_in.key;
      attr_q <= tok_in.attr;
    end
  end

  // Mark occupancy and hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      if (wr) begin
        used <= 1'b1;
      end
      tok_out <= tok_next;
    end
  end

endmodule
